// ===== src/lpmd_pkg.sv =====
// Shared types and constants of the length-prefixed message deframer.
// Used by the front, the back, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lpmd_pkg;

   // Frame length limits, counting the message id and the payload.
   localparam logic [16:0] FRAME_LIMIT = 17'd65536;
   localparam logic [31:0] MIN_FRAME   = 32'd4;

   // The last byte of a four-byte header.
   localparam logic [1:0] HEADER_LAST = 2'd3;

   // Result kinds as they appear on the result channel.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Stream phase of the front.
   typedef enum logic [1:0] {
      PHASE_LENGTH,
      PHASE_ID,
      PHASE_PAYLOAD,
      PHASE_CLOSED
   } phase_type;

   // Commands passed from the front to the back.
   typedef enum logic [1:0] {
      CMD_ID_BYTE,     // id byte, no result
      CMD_ID_EMPTY,    // last id byte of a frame without payload
      CMD_PAYLOAD,     // payload byte
      CMD_ERROR        // illegal length, connection closed
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       last;
   } cmd_entry_type;

endpackage

`default_nettype wire

// ===== src/length_prefixed_message_deframer.sv =====
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg, lpmd_front, lpmd_queue and lpmd_back.
//
//   Channel   Prefix  Direction  Contents
//   input     req_    in         rx_byte, one stream byte per word
//   result    rsp_    out        result_kind, message_id, payload_byte, end_of_message
//   register  csr_    in         max_frame_length, write only
//
// One word is taken per clock cycle while req_stall is low; a payload byte is written into
// the queue at the edge that takes it and moves on to the output register when it is free,
// for the receiver to take. Reset is synchronous and needs no clearing pass. A stall on
// the result channel is absorbed by the output register and the command queue of QUEUE_DEPTH
// words, after which req_stall rises; header words keep flowing while the queue has room.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_message_deframer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_result_kind,
   output logic signed [31:0]       rsp_message_id,
   output logic [7:0]               rsp_payload_byte,
   output logic                     rsp_end_of_message,
   input  wire logic                csr_write_enable,
   input  wire logic [16:0]         csr_write_data
);

   localparam int unsigned ENTRY_W = $bits(lpmd_pkg::cmd_entry_type);

   lpmd_pkg::cmd_entry_type push_entry;
   lpmd_pkg::cmd_entry_type pop_entry;
   logic                    push_valid;
   logic                    queue_full;
   logic                    queue_not_empty;
   logic                    cmd_pop;
   logic [ENTRY_W-1:0]      pop_bits;

   // Header parsing and length check.
   lpmd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .queue_full       (queue_full)
   );

   // Command queue.
   lpmd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_data  (pop_bits),
      .not_empty (queue_not_empty)
   );

   assign pop_entry = lpmd_pkg::cmd_entry_type'(pop_bits);

   // Result formation.
   lpmd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (queue_not_empty),
      .cmd_entry          (pop_entry),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_message_id     (rsp_message_id),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

`default_nettype wire

// ===== src/lpmd_front.sv =====
// Front of the deframer: takes words, gathers and checks the length header.
// Depends on lpmd_pkg; pushes classified commands into the command queue.
`timescale 1ns / 1ps
`default_nettype none

module lpmd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  csr_write_enable,
   input  wire logic [16:0]           csr_write_data,
   output logic                       push_valid,
   output lpmd_pkg::cmd_entry_type    push_entry,
   input  wire logic                  queue_full
);

   lpmd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          count_ff, count_in;
   logic [31:0]         length_ff, length_in;
   logic [16:0]         remaining_ff, remaining_in;
   logic [16:0]         max_length_ff;
   logic [16:0]         limit;
   logic [31:0]         length_next;
   logic                length_ok;
   logic                accept;

   // Maximum frame length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= lpmd_pkg::FRAME_LIMIT;
      end else if (csr_write_enable) begin
         max_length_ff <= csr_write_data;
      end
   end

   // Phase and header counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lpmd_pkg::PHASE_LENGTH;
         count_ff     <= '0;
         remaining_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
      end
   end

   // Length bytes are fully replaced before they are used.
   always_ff @(posedge clock) begin
      length_ff <= length_in;
   end

   // A word is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Length check on the header as it completes.
   assign length_next = {length_ff[23:0], req_rx_byte};
   assign limit       = (max_length_ff > lpmd_pkg::FRAME_LIMIT) ?
                        lpmd_pkg::FRAME_LIMIT : max_length_ff;
   assign length_ok   = !length_next[31] && (length_next >= lpmd_pkg::MIN_FRAME) &&
                        (length_next <= {15'd0, limit});

   // Next phase and the command for the accepted word.
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      length_in       = length_ff;
      remaining_in    = remaining_ff;
      push_valid      = 1'b0;
      push_entry.cmd  = lpmd_pkg::CMD_ID_BYTE;
      push_entry.data = req_rx_byte;
      push_entry.last = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            lpmd_pkg::PHASE_LENGTH: begin
               length_in = length_next;
               if (count_ff != lpmd_pkg::HEADER_LAST) begin
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in = '0;
                  if (length_ok) begin
                     remaining_in = 17'(length_next - lpmd_pkg::MIN_FRAME);
                     phase_in     = lpmd_pkg::PHASE_ID;
                  end else begin
                     phase_in        = lpmd_pkg::PHASE_CLOSED;
                     push_valid      = 1'b1;
                     push_entry.cmd  = lpmd_pkg::CMD_ERROR;
                     push_entry.last = 1'b1;
                  end
               end
            end
            lpmd_pkg::PHASE_ID: begin
               push_valid = 1'b1;
               if (count_ff != lpmd_pkg::HEADER_LAST) begin
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in = '0;
                  if (remaining_ff == '0) begin
                     phase_in        = lpmd_pkg::PHASE_LENGTH;
                     push_entry.cmd  = lpmd_pkg::CMD_ID_EMPTY;
                     push_entry.last = 1'b1;
                  end else begin
                     phase_in = lpmd_pkg::PHASE_PAYLOAD;
                  end
               end
            end
            lpmd_pkg::PHASE_PAYLOAD: begin
               push_valid      = 1'b1;
               push_entry.cmd  = lpmd_pkg::CMD_PAYLOAD;
               remaining_in    = remaining_ff - 17'd1;
               push_entry.last = (remaining_ff == 17'd1);
               if (remaining_ff == 17'd1) begin
                  phase_in = lpmd_pkg::PHASE_LENGTH;
               end
            end
            lpmd_pkg::PHASE_CLOSED: begin
               // Dropped until reset.
               phase_in = lpmd_pkg::PHASE_CLOSED;
            end
            default: begin
               phase_in = lpmd_pkg::PHASE_CLOSED;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/lpmd_queue.sv =====
// Short command queue between the front and the back of the deframer.
// Generic width and depth; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module lpmd_queue #(
   parameter int unsigned WIDTH = 11,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entries_ff[rd_ptr_ff];

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/lpmd_back.sv =====
// Back of the deframer: gathers the message id and forms result words.
// Depends on lpmd_pkg; drains the command queue into the output register.
`timescale 1ns / 1ps
`default_nettype none

module lpmd_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_valid,
   input  wire lpmd_pkg::cmd_entry_type  cmd_entry,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic signed [31:0]            rsp_message_id,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_end_of_message
);

   logic [31:0] id_ff, id_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] msg_id_ff, msg_id_in;
   logic [7:0]  byte_ff, byte_in;
   logic        eom_ff, eom_in;
   logic        is_result;
   logic        slot_free;
   logic        load;

   // Id bytes pass straight through; results wait for a free output slot.
   assign is_result = (cmd_entry.cmd != lpmd_pkg::CMD_ID_BYTE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop   = cmd_valid && (!is_result || slot_free);
   assign load      = cmd_pop && is_result;

   // Id shift register and the fields of the next result.
   always_comb begin
      id_in     = id_ff;
      kind_in   = kind_ff;
      msg_id_in = msg_id_ff;
      byte_in   = byte_ff;
      eom_in    = eom_ff;
      if (cmd_pop && (cmd_entry.cmd == lpmd_pkg::CMD_ID_BYTE ||
                      cmd_entry.cmd == lpmd_pkg::CMD_ID_EMPTY)) begin
         id_in = {id_ff[23:0], cmd_entry.data};
      end
      if (load) begin
         unique case (cmd_entry.cmd)
            lpmd_pkg::CMD_PAYLOAD: begin
               kind_in   = lpmd_pkg::KIND_PAYLOAD;
               msg_id_in = id_ff;
               byte_in   = cmd_entry.data;
               eom_in    = cmd_entry.last;
            end
            lpmd_pkg::CMD_ID_EMPTY: begin
               kind_in   = lpmd_pkg::KIND_EMPTY;
               msg_id_in = {id_ff[23:0], cmd_entry.data};
               byte_in   = '0;
               eom_in    = 1'b1;
            end
            lpmd_pkg::CMD_ERROR: begin
               kind_in   = lpmd_pkg::KIND_ERROR;
               msg_id_in = '0;
               byte_in   = '0;
               eom_in    = 1'b1;
            end
            default: begin
               kind_in = kind_ff;
            end
         endcase
      end
   end

   // The output word stays valid until it is taken.
   always_comb begin
      if (slot_free) begin
         rsp_valid_in = load;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      kind_ff   <= kind_in;
      msg_id_ff <= msg_id_in;
      byte_ff   <= byte_in;
      eom_ff    <= eom_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_message_id     = signed'(msg_id_ff);
   assign rsp_payload_byte   = byte_ff;
   assign rsp_end_of_message = eom_ff;

endmodule

`default_nettype wire

// ===== src/lpmd_checker.sv =====
// Port-level checker for the length-prefixed message deframer, with its bind.
// Depends on lpmd_pkg; sees only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module lpmd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_result_kind,
   input wire logic signed [31:0] rsp_message_id,
   input wire logic [7:0]         rsp_payload_byte,
   input wire logic               rsp_end_of_message
);

   // No result word is shown in the cycle after reset.
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word stays and holds its fields.
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_message_id) && $stable(rsp_payload_byte) &&
         $stable(rsp_end_of_message))
      else $error("stalled result changed");

   // The error result carries a zero id and byte and ends the message.
   a_error_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == lpmd_pkg::KIND_ERROR |->
         rsp_message_id == 32'sd0 && rsp_payload_byte == 8'd0 && rsp_end_of_message)
      else $error("malformed error result");

   // An empty message has no payload byte and ends its frame.
   a_empty_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == lpmd_pkg::KIND_EMPTY |->
         rsp_payload_byte == 8'd0 && rsp_end_of_message)
      else $error("malformed empty-message result");

endmodule

bind length_prefixed_message_deframer lpmd_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_message_id     (rsp_message_id),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_end_of_message (rsp_end_of_message)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the length-prefixed message deframer: framed byte streams
// go in with random gaps and stalls, and every result word is checked against a predictor.
// Depends on lpmd_pkg and length_prefixed_message_deframer.

module testbench;

   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] id;
      logic [7:0]         data;
      logic               last;
   } result_word_type;

   // Follows the deframer state word by word, predicts the result words and checks
   // the words that leave against the oldest prediction.
   class frame_tracker;
      lpmd_pkg::phase_type phase;
      logic [1:0]          header_count;
      logic [31:0]         length_shift;
      logic [31:0]         id_shift;
      logic [16:0]         payload_left;
      logic [16:0]         max_length;
      result_word_type     awaited_words[$];
      int                  mismatches;

      function new();
         phase        = lpmd_pkg::PHASE_LENGTH;
         header_count = '0;
         length_shift = '0;
         id_shift     = '0;
         payload_left = '0;
         max_length   = lpmd_pkg::FRAME_LIMIT;
         mismatches   = 0;
      endfunction

      function void set_max_length(logic [16:0] value);
         max_length = value;
      endfunction

      // Register values above the frame limit are saturated.
      function logic [16:0] length_ceiling();
         return (max_length > lpmd_pkg::FRAME_LIMIT) ? lpmd_pkg::FRAME_LIMIT : max_length;
      endfunction

      function void take_word(logic [7:0] data);
         result_word_type word;
         word = '0;
         case (phase)
            lpmd_pkg::PHASE_LENGTH: begin
               length_shift = {length_shift[23:0], data};
               if (header_count != lpmd_pkg::HEADER_LAST) begin
                  header_count++;
               end else begin
                  header_count = '0;
                  // A set top bit is a negative length and is always illegal.
                  if (length_shift[31] || length_shift < lpmd_pkg::MIN_FRAME ||
                      length_shift > {15'd0, length_ceiling()}) begin
                     phase     = lpmd_pkg::PHASE_CLOSED;
                     word.kind = lpmd_pkg::KIND_ERROR;
                     word.last = 1'b1;
                     awaited_words.push_back(word);
                  end else begin
                     payload_left = 17'(length_shift - lpmd_pkg::MIN_FRAME);
                     id_shift     = '0;
                     phase        = lpmd_pkg::PHASE_ID;
                  end
               end
            end
            lpmd_pkg::PHASE_ID: begin
               id_shift = {id_shift[23:0], data};
               if (header_count != lpmd_pkg::HEADER_LAST) begin
                  header_count++;
               end else begin
                  header_count = '0;
                  length_shift = '0;
                  if (payload_left == '0) begin
                     phase     = lpmd_pkg::PHASE_LENGTH;
                     word.kind = lpmd_pkg::KIND_EMPTY;
                     word.id   = id_shift;
                     word.last = 1'b1;
                     awaited_words.push_back(word);
                  end else begin
                     phase = lpmd_pkg::PHASE_PAYLOAD;
                  end
               end
            end
            lpmd_pkg::PHASE_PAYLOAD: begin
               payload_left = payload_left - 17'd1;
               word.kind    = lpmd_pkg::KIND_PAYLOAD;
               word.id      = id_shift;
               word.data    = data;
               word.last    = (payload_left == '0);
               if (payload_left == '0) begin
                  phase = lpmd_pkg::PHASE_LENGTH;
               end
               awaited_words.push_back(word);
            end
            default: begin
               // Closed: the word is dropped.
            end
         endcase
      endfunction

      task note_mismatch(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task match_word(result_word_type got);
         result_word_type want;
         if (awaited_words.size() == 0) begin
            note_mismatch($sformatf("unexpected word kind %0d id %0d data %0h",
                                    got.kind, got.id, got.data));
            return;
         end
         want = awaited_words.pop_front();
         if (got.kind !== want.kind) begin
            note_mismatch($sformatf("result_kind %0d, predicted %0d", got.kind, want.kind));
         end
         if (got.id !== want.id) begin
            note_mismatch($sformatf("message_id %0d, predicted %0d", got.id, want.id));
         end
         if (got.data !== want.data) begin
            note_mismatch($sformatf("payload_byte %0h, predicted %0h", got.data, want.data));
         end
         if (got.last !== want.last) begin
            note_mismatch($sformatf("end_of_message %0b, predicted %0b", got.last, want.last));
         end
      endtask
   endclass

   logic               clock;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte        = '0;
   logic               rsp_valid;
   logic               rsp_stall          = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic signed [31:0] rsp_message_id;
   logic [7:0]         rsp_payload_byte;
   logic               rsp_end_of_message;
   logic               csr_write_enable   = 1'b0;
   logic [16:0]        csr_write_data     = '0;

   frame_tracker tracker = new();
   bit           gaps_on     = 1'b1;
   int           words_sent  = 0;
   int           hold_ticket = 0;
   int           hold_served = 0;
   int           hold_left   = 0;

   length_prefixed_message_deframer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_message_id     (rsp_message_id),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_end_of_message (rsp_end_of_message),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_ticket) begin
         rsp_stall   <= 1'b1;
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < 34);
      end
   end

   // Every result word taken by the receiver is checked.
   always @(posedge clock) begin : result_check
      result_word_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind = rsp_result_kind;
         seen.id   = rsp_message_id;
         seen.data = rsp_payload_byte;
         seen.last = rsp_end_of_message;
         tracker.match_word(seen);
      end
   end

   // Offers one word, with random idle cycles first, and returns once it is taken.
   task automatic send_word(input logic [7:0] data);
      while (gaps_on && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_word(data);
      words_sent++;
   endtask

   // Waits until every predicted word has come, then lets the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [16:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_max_length(value);
   endtask

   function automatic logic [16:0] pick_max_length();
      case ($urandom_range(0, 5))
         0:       return 17'd4;
         1:       return lpmd_pkg::FRAME_LIMIT;
         2:       return 17'h1FFFF;
         3:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(5, 300));
      endcase
   endfunction

   // Sends a length field, a message id and payload_count random payload words. At word
   // split_at the stream pauses and the maximum length is rewritten mid-frame.
   task automatic send_frame(input logic [31:0] length_field, input logic [31:0] id,
                             input int payload_count, input int split_at);
      for (int i = 0; i < payload_count + 8; i++) begin
         if (i == split_at) begin
            write_max_length(pick_max_length());
         end
         if (i < 4) begin
            send_word(length_field[31 - 8 * i -: 8]);
         end else if (i < 8) begin
            send_word(id[63 - 8 * i -: 8]);
         end else begin
            send_word(8'($urandom));
         end
      end
   endtask

   // A legal frame: mostly short payloads, now and then, under a small ceiling, one of the largest legal length.
   task automatic send_random_frame();
      int unsigned ceiling;
      int unsigned room;
      int unsigned pick;
      int          payload_count;
      int          split_at;
      logic [31:0] id;
      ceiling = tracker.length_ceiling();
      room    = ceiling - 4;
      pick    = $urandom_range(0, 99);
      if (pick < 12 || room == 0) begin
         payload_count = 0;
      end else if (pick < 80) begin
         payload_count = $urandom_range(1, (room < 12) ? room : 12);
      end else if (pick < 92) begin
         payload_count = $urandom_range(1, (room < 60) ? room : 60);
      end else begin
         payload_count = (ceiling <= 300) ? room : $urandom_range(0, 60);
      end
      case ($urandom_range(0, 9))
         0:       id = 32'h8000_0000;
         1:       id = 32'h7FFF_FFFF;
         2:       id = 32'h0000_0000;
         3:       id = 32'hFFFF_FFFF;
         default: id = $urandom;
      endcase
      split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(4, payload_count + 7) : -1;
      send_frame(payload_count + 4, id, payload_count, split_at);
   endtask

   // One illegal length closes the connection; the words after it must be dropped.
   task automatic close_connection();
      logic [31:0] bad_length;
      case ($urandom_range(0, 3))
         0: bad_length = {1'b1, 31'($urandom)};
         1: bad_length = $urandom_range(0, 3);
         2: begin
            if ($urandom_range(0, 1) == 1) begin
               write_max_length(17'h1FFFF);
               bad_length = $urandom_range(65537, 32'h7FFF_FFFF);
            end else begin
               write_max_length(17'($urandom_range(4, 65535)));
               bad_length = tracker.length_ceiling() + $urandom_range(1, 3);
            end
         end
         default: begin
            // With a maximum below four no length is legal.
            write_max_length(17'($urandom_range(0, 3)));
            bad_length = $urandom_range(0, 300);
         end
      endcase
      send_frame(bad_length, $urandom, $urandom_range(10, 30), -1);
   endtask

   // Stimulus.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme ids, empty and one-word frames, the smallest and saturated maxima.
      send_frame(32'd4, 32'h8000_0000, 0, -1);
      send_frame(32'd4, 32'h7FFF_FFFF, 0, -1);
      send_frame(32'd5, 32'hFFFF_FFFF, 1, -1);
      write_max_length(17'd4);
      send_frame(32'd4, 32'h0000_0000, 0, -1);
      write_max_length(17'h1FFFF);
      send_frame(32'd6, 32'h0123_4567, 2, 6);
      write_max_length(lpmd_pkg::FRAME_LIMIT);

      // The receiver holds off while a long frame keeps coming, so the input stalls.
      hold_ticket++;
      send_frame(32'd84, $urandom, 80, -1);
      wait_idle();

      // A long frame with no idling on either side.
      gaps_on = 1'b0;
      send_frame(32'd204, $urandom, 200, -1);
      gaps_on = 1'b1;

      // Random legal frames under changing maxima.
      while (words_sent < 1000) begin
         if ($urandom_range(0, 19) == 0) begin
            write_max_length(pick_max_length());
         end
         send_random_frame();
      end

      close_connection();
      wait_idle();
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/lpmd_pkg.sv
src/lpmd_front.sv
src/lpmd_queue.sv
src/lpmd_back.sv
src/length_prefixed_message_deframer.sv
src/lpmd_checker.sv
tb/testbench.sv
